/* rtl/dlpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpe_pkg
// Shared types and constants of the line-number program engine.
// ----------------------------------------------------------------------------
package dlpe_pkg;

    localparam int ADDR_W = 28;
    localparam int FILE_W = 16;
    localparam int LINE_W = 16;
    localparam int COL_W  = 10;
    localparam int DISC_W = 28;

    // parse phases
    typedef enum logic [3:0] {
        PH_OPCODE   = 4'd0,
        PH_EXT_LEN  = 4'd1,
        PH_EXT_SUB  = 4'd2,
        PH_EXT_ADDR = 4'd3,
        PH_EXT_DISC = 4'd4,
        PH_ADV_PC   = 4'd5,
        PH_ADV_LINE = 4'd6,
        PH_SET_FILE = 4'd7,
        PH_SET_COL  = 4'd8,
        PH_FIXED_PC = 4'd9,
        PH_SET_ISA  = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_SOFT = 2'd1,
        RES_FULL = 2'd2
    } resume_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_APPLY = 2'd2
    } bk_state_t;

    // standard opcodes
    localparam logic [7:0] OP_EXTENDED   = 8'd0;
    localparam logic [7:0] OP_COPY       = 8'd1;
    localparam logic [7:0] OP_ADV_PC     = 8'd2;
    localparam logic [7:0] OP_ADV_LINE   = 8'd3;
    localparam logic [7:0] OP_SET_FILE   = 8'd4;
    localparam logic [7:0] OP_SET_COL    = 8'd5;
    localparam logic [7:0] OP_NEG_STMT   = 8'd6;
    localparam logic [7:0] OP_SET_BB     = 8'd7;
    localparam logic [7:0] OP_CONST_ADD  = 8'd8;
    localparam logic [7:0] OP_FIXED_PC   = 8'd9;
    localparam logic [7:0] OP_SET_PRO    = 8'd10;
    localparam logic [7:0] OP_SET_EPI    = 8'd11;
    localparam logic [7:0] OP_SET_ISA    = 8'd12;
    localparam logic [7:0] EXT_END_SEQ   = 8'd1;
    localparam logic [7:0] EXT_SET_ADDR  = 8'd2;
    localparam logic [7:0] EXT_SET_DISC  = 8'd4;

    // commands handed from front to back
    typedef enum logic [3:0] {
        CMD_RESTART  = 4'd0,
        CMD_NOP      = 4'd1,
        CMD_SPECIAL  = 4'd2,
        CMD_COPY     = 4'd3,
        CMD_NEG_STMT = 4'd4,
        CMD_SET_BB   = 4'd5,
        CMD_CONST_ADD = 4'd6,
        CMD_SET_PRO  = 4'd7,
        CMD_SET_EPI  = 4'd8,
        CMD_ILLEGAL  = 4'd9,
        CMD_END_SEQ  = 4'd10,
        CMD_SET_ADDR = 4'd11,
        CMD_ADD_ADDR = 4'd12,
        CMD_SET_DISC = 4'd13,
        CMD_SET_FILE = 4'd14,
        CMD_SET_COL  = 4'd15
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        add_line;   // operand adds to line instead
        logic [31:0] operand;
        logic [7:0]  adj;        // dividend for special/const_add
    } cmd_pkt_t;

    localparam int CMD_PKT_W = $bits(cmd_pkt_t);

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] address;
        logic [FILE_W-1:0] file;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic              is_stmt;
        logic              basic_block;
        logic              end_seq;
        logic              pro_end;
        logic              epilogue_begin;
        logic [DISC_W-1:0] discriminator;
    } row_t;

endpackage

/* rtl/dwarf_line_program_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwarf_line_program_engine
// Line-number program decoder: parser front end, command queue, register
// engine with a serial divider, APB configuration registers.
// ----------------------------------------------------------------------------
// a byte that completes an instruction is queued as a command; the single
// register engine takes it while idle, runs the 8-step divider for special
// opcodes and const_add_pc, then applies it and registers any row for m_tvalid;
// it handles one command at a time behind a 2-entry queue, stalls on m_tready
// reset: synchronous active-low aresetn restores config and row registers
module dwarf_line_program_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // code_byte [7:0]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [103:0] m_tdata,  // address, file, line, column, is_stmt,
                                   // basic_block, end_seq, pro_end,
                                   // epilogue_begin, discriminator; zero fill
    output logic        m_tuser,   // row_status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dlpe_pkg::*;

    localparam logic [1:0] REG_DEF_STMT = 2'd0;
    localparam logic [1:0] REG_LINE_BASE = 2'd1;
    localparam logic [1:0] REG_LINE_RANGE = 2'd2;
    localparam logic [1:0] REG_OPCODE_BASE = 2'd3;

    logic       def_stmt_reg;
    logic [7:0] lbase_reg, lrange_reg, obase_reg;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_pkt_t   fq_data, qb_data;
    row_t       row;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_stmt_reg <= 1'b1;
            lbase_reg    <= 8'hFB;
            lrange_reg   <= 8'd14;
            obase_reg    <= 8'd13;
        end else if (wr_en && paddr[1:0] == 2'd0) begin
            case (paddr[3:2])
                REG_DEF_STMT:    def_stmt_reg <= pwdata[0];
                REG_LINE_BASE:   lbase_reg    <= pwdata[7:0];
                REG_LINE_RANGE:  lrange_reg   <= pwdata[7:0];
                REG_OPCODE_BASE: obase_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEF_STMT:    prdata = {31'd0, def_stmt_reg};
            REG_LINE_BASE:   prdata = {24'd0, lbase_reg};
            REG_LINE_RANGE:  prdata = {24'd0, lrange_reg};
            REG_OPCODE_BASE: prdata = {24'd0, obase_reg};
            default:         prdata = '0;
        endcase
    end

    dlpe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_byte     (s_tdata),
        .obase       (obase_reg),
        .cmd_valid   (fq_valid),
        .cmd_ready   (fq_ready),
        .cmd_data    (fq_data)
    );

    dlpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    dlpe_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (qb_valid),
        .cmd_ready       (qb_ready),
        .cmd_data        (qb_data),
        .def_stmt        (def_stmt_reg),
        .lbase           (lbase_reg),
        .lrange          (lrange_reg),
        .row_valid       (m_tvalid),
        .row_ready       (m_tready),
        .row_data        (row)
    );

    assign m_tuser = row.status;
    assign m_tdata = {1'b0, row.discriminator, row.epilogue_begin, row.pro_end,
                      row.end_seq, row.basic_block, row.is_stmt, row.column,
                      row.line, row.file, row.address};

endmodule

/* rtl/dlpe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpe_front
// Parses program bytes and assembles operands into back-end commands.
// ----------------------------------------------------------------------------
module dlpe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    input  logic [7:0]           in_byte,
    input  logic [7:0]           obase,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output dlpe_pkg::cmd_pkt_t   cmd_data
);
    import dlpe_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic        out_valid;
    cmd_pkt_t    pkt;
    logic        take;
    logic        last_leb;
    logic [31:0] leb_acc;
    logic [31:0] le_acc;
    logic [5:0]  le_shift;
    logic [31:0] sext_v;

    assign in_ready  = cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = take && out_valid;
    assign cmd_data  = pkt;
    assign last_leb  = !in_byte[7];

    always_comb begin
        leb_acc = acc_reg;
        if (shift_reg < 6'd31) begin
            leb_acc = acc_reg | ({25'd0, in_byte[6:0]} << shift_reg[4:0]);
        end
        le_acc   = acc_reg;
        le_shift = shift_reg;
        if (shift_reg < 6'd32) begin
            le_acc   = acc_reg | ({24'd0, in_byte} << shift_reg[4:0]);
            le_shift = shift_reg + 6'd8;
        end
        sext_v = leb_acc;
        if (shift_reg < 6'd24) begin
            // shift after this byte is shift_reg+7, below 31
            if (leb_acc[shift_reg[4:0] + 5'd6]) begin
                sext_v = leb_acc | (32'hFFFF_FFFF << (shift_reg[4:0] + 5'd7));
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        out_valid  = 1'b0;
        pkt        = '0;
        pkt.cmd    = CMD_NOP;
        if (in_op) begin
            out_valid  = 1'b1;
            pkt.cmd    = CMD_RESTART;
            phase_next = PH_OPCODE;
            acc_next   = '0;
            shift_next = '0;
        end else begin
            out_valid = 1'b1;
            case (phase_reg)
                PH_OPCODE: begin
                    acc_next   = '0;
                    shift_next = '0;
                    if (in_byte >= obase) begin
                        pkt.cmd = CMD_SPECIAL;
                        pkt.adj = in_byte - obase;
                    end else begin
                        case (in_byte)
                            OP_EXTENDED:  phase_next = PH_EXT_LEN;
                            OP_COPY:      pkt.cmd = CMD_COPY;
                            OP_ADV_PC:    phase_next = PH_ADV_PC;
                            OP_ADV_LINE:  phase_next = PH_ADV_LINE;
                            OP_SET_FILE:  phase_next = PH_SET_FILE;
                            OP_SET_COL:   phase_next = PH_SET_COL;
                            OP_NEG_STMT:  pkt.cmd = CMD_NEG_STMT;
                            OP_SET_BB:    pkt.cmd = CMD_SET_BB;
                            OP_CONST_ADD: begin
                                pkt.cmd = CMD_CONST_ADD;
                                pkt.adj = 8'd255 - obase;
                            end
                            OP_FIXED_PC:  phase_next = PH_FIXED_PC;
                            OP_SET_PRO:   pkt.cmd = CMD_SET_PRO;
                            OP_SET_EPI:   pkt.cmd = CMD_SET_EPI;
                            OP_SET_ISA:   phase_next = PH_SET_ISA;
                            default:      pkt.cmd = CMD_ILLEGAL;
                        endcase
                    end
                end
                PH_EXT_LEN: begin
                    if (shift_reg < 6'd31) begin
                        shift_next = shift_reg + 6'd7;
                    end
                    acc_next = leb_acc;
                    if (last_leb) begin
                        phase_next = PH_EXT_SUB;
                    end
                end
                PH_EXT_SUB: begin
                    phase_next = PH_OPCODE;
                    acc_next   = '0;
                    shift_next = '0;
                    case (in_byte)
                        EXT_END_SEQ:  pkt.cmd = CMD_END_SEQ;
                        EXT_SET_ADDR: phase_next = PH_EXT_ADDR;
                        EXT_SET_DISC: phase_next = PH_EXT_DISC;
                        default:      pkt.cmd = CMD_ILLEGAL;
                    endcase
                end
                PH_EXT_ADDR, PH_FIXED_PC: begin
                    acc_next   = le_acc;
                    shift_next = le_shift;
                    if (phase_reg == PH_EXT_ADDR && le_shift >= 6'd32) begin
                        pkt.cmd     = CMD_SET_ADDR;
                        pkt.operand = le_acc;
                        phase_next  = PH_OPCODE;
                    end else if (phase_reg == PH_FIXED_PC && le_shift >= 6'd16) begin
                        pkt.cmd     = CMD_ADD_ADDR;
                        pkt.operand = {16'd0, le_acc[15:0]};
                        phase_next  = PH_OPCODE;
                    end
                end
                PH_EXT_DISC, PH_ADV_PC, PH_SET_FILE, PH_SET_COL, PH_SET_ISA,
                PH_ADV_LINE: begin
                    if (shift_reg < 6'd31) begin
                        shift_next = shift_reg + 6'd7;
                    end
                    acc_next = leb_acc;
                    if (last_leb) begin
                        phase_next  = PH_OPCODE;
                        pkt.operand = leb_acc;
                        case (phase_reg)
                            PH_EXT_DISC: pkt.cmd = CMD_SET_DISC;
                            PH_ADV_PC:   pkt.cmd = CMD_ADD_ADDR;
                            PH_SET_FILE: pkt.cmd = CMD_SET_FILE;
                            PH_SET_COL:  pkt.cmd = CMD_SET_COL;
                            PH_ADV_LINE: begin
                                pkt.cmd      = CMD_ADD_ADDR;
                                pkt.add_line = 1'b1;
                                pkt.operand  = sext_v;
                            end
                            default:     pkt.cmd = CMD_NOP;
                        endcase
                    end
                end
                default: phase_next = PH_OPCODE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPCODE;
            acc_reg   <= '0;
            shift_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
        end
    end

    property p_restart_clears;
        @(posedge aclk) disable iff (!aresetn)
            (take && in_op) |=> (phase_reg == PH_OPCODE && shift_reg == 6'd0);
    endproperty
    a_restart_clears: assert property (p_restart_clears)
        else $error("restart did not return parser to opcode phase");

    property p_shift_bound;
        @(posedge aclk) disable iff (!aresetn) shift_reg <= 6'd40;
    endproperty
    a_shift_bound: assert property (p_shift_bound)
        else $error("operand shift out of range");

    property p_cmd_on_take;
        @(posedge aclk) disable iff (!aresetn) cmd_valid |-> take;
    endproperty
    a_cmd_on_take: assert property (p_cmd_on_take)
        else $error("command issued without input transaction");

endmodule

/* rtl/dlpe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpe_queue
// Two-entry command queue between parser and register engine.
// ----------------------------------------------------------------------------
module dlpe_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  dlpe_pkg::cmd_pkt_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output dlpe_pkg::cmd_pkt_t rd_data
);
    import dlpe_pkg::*;

    cmd_pkt_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue count out of range");

    property p_ptr_match;
        @(posedge aclk) disable iff (!aresetn)
            (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wp_reg == rp_reg);
    endproperty
    a_ptr_match: assert property (p_ptr_match)
        else $error("queue pointers inconsistent with count");

    property p_empty_after_drain;
        @(posedge aclk) disable iff (!aresetn)
            (cnt_reg == 2'd1 && pop && !push) |=> !rd_valid;
    endproperty
    a_empty_after_drain: assert property (p_empty_after_drain)
        else $error("queue not empty after last pop");

endmodule

/* rtl/dlpe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpe_back
// Row register engine: applies commands, runs the special-opcode divider
// and holds a result register for the output stream.
// ----------------------------------------------------------------------------
module dlpe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  dlpe_pkg::cmd_pkt_t cmd_data,
    input  logic               def_stmt,
    input  logic [7:0]         lbase,
    input  logic [7:0]         lrange,
    output logic               row_valid,
    input  logic               row_ready,
    output dlpe_pkg::row_t     row_data
);
    import dlpe_pkg::*;

    bk_state_t         state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [FILE_W-1:0] file_reg, file_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [4:0]        flag_reg, flag_next;
    logic [DISC_W-1:0] disc_reg, disc_next;
    resume_t           resume_reg, resume_next;
    cmd_pkt_t          cur_reg, cur_next;
    logic [7:0]        quo_reg, quo_next;
    logic [7:0]        rem_reg, rem_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              ovalid_reg, ovalid_next;
    row_t              row_reg, row_next;
    logic [8:0]        trial;
    logic [7:0]        q_eff, r_eff;
    logic              emit, illegal;

    assign row_valid = ovalid_reg;
    assign row_data  = row_reg;
    assign trial     = {rem_reg, cur_reg.adj[3'd7 - cnt_reg[2:0]]} - {1'b0, lrange};
    assign q_eff     = (lrange == 8'd0) ? 8'd255 : quo_reg;
    assign r_eff     = (lrange == 8'd0) ? cur_reg.adj : rem_reg;

    always_comb begin
        cmd_ready = (state_reg == BK_IDLE) && (!ovalid_reg || row_ready);
    end

    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        file_next   = file_reg;
        line_next   = line_reg;
        column_next = column_reg;
        flag_next   = flag_reg;
        disc_next   = disc_reg;
        resume_next = resume_reg;
        cur_next    = cur_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !row_ready;
        row_next    = row_reg;
        emit        = 1'b0;
        illegal     = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    cur_next = cmd_data;
                    if (cmd_data.cmd == CMD_RESTART) begin
                        addr_next   = '0;
                        file_next   = FILE_W'(1);
                        line_next   = LINE_W'(1);
                        column_next = '0;
                        flag_next   = {4'd0, def_stmt};
                        disc_next   = '0;
                        resume_next = RES_NONE;
                    end else begin
                        if (resume_reg == RES_FULL) begin
                            addr_next   = '0;
                            file_next   = FILE_W'(1);
                            line_next   = LINE_W'(1);
                            column_next = '0;
                            flag_next   = {4'd0, def_stmt};
                            disc_next   = '0;
                        end else if (resume_reg == RES_SOFT) begin
                            disc_next = '0;
                            flag_next = flag_reg & 5'b00101;
                        end
                        resume_next = RES_NONE;
                        state_next  = BK_APPLY;
                        if (cmd_data.cmd == CMD_SPECIAL || cmd_data.cmd == CMD_CONST_ADD) begin
                            state_next = BK_DIV;
                            quo_next   = '0;
                            rem_next   = '0;
                            cnt_next   = '0;
                        end
                    end
                end
            end
            BK_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (!trial[8]) begin
                    rem_next = trial[7:0];
                    quo_next = {quo_reg[6:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[6:0], cur_reg.adj[3'd7 - cnt_reg[2:0]]};
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7) begin
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY: begin
                state_next = BK_IDLE;
                case (cur_reg.cmd)
                    CMD_SPECIAL: begin
                        addr_next = addr_reg + ADDR_W'(q_eff);
                        line_next = line_reg + {{8{lbase[7]}}, lbase}
                                  + LINE_W'(r_eff);
                        emit = 1'b1;
                    end
                    CMD_CONST_ADD: addr_next = addr_reg + ADDR_W'(q_eff);
                    CMD_COPY:     emit = 1'b1;
                    CMD_NEG_STMT: flag_next = flag_reg ^ 5'b00001;
                    CMD_SET_BB:   flag_next = flag_reg | 5'b00010;
                    CMD_SET_PRO:  flag_next = flag_reg | 5'b01000;
                    CMD_SET_EPI:  flag_next = flag_reg | 5'b10000;
                    CMD_ILLEGAL:  illegal = 1'b1;
                    CMD_END_SEQ: begin
                        flag_next   = flag_reg | 5'b00100;
                        emit        = 1'b1;
                        resume_next = RES_FULL;
                    end
                    CMD_SET_ADDR: addr_next = cur_reg.operand[ADDR_W-1:0];
                    CMD_ADD_ADDR: begin
                        if (cur_reg.add_line) begin
                            line_next = line_reg + cur_reg.operand[LINE_W-1:0];
                        end else begin
                            addr_next = addr_reg + cur_reg.operand[ADDR_W-1:0];
                        end
                    end
                    CMD_SET_DISC: disc_next = cur_reg.operand[DISC_W-1:0];
                    CMD_SET_FILE: file_next = cur_reg.operand[FILE_W-1:0];
                    CMD_SET_COL:  column_next = cur_reg.operand[COL_W-1:0];
                    default: ;
                endcase
                if (illegal) begin
                    resume_next = RES_FULL;
                end else if (emit && cur_reg.cmd != CMD_END_SEQ) begin
                    resume_next = RES_SOFT;
                end
                if (emit || illegal) begin
                    ovalid_next            = 1'b1;
                    row_next.status        = illegal;
                    row_next.address       = addr_next;
                    row_next.file          = file_next;
                    row_next.line          = line_next;
                    row_next.column        = column_next;
                    row_next.is_stmt       = flag_next[0];
                    row_next.basic_block   = flag_next[1];
                    row_next.end_seq       = flag_next[2];
                    row_next.pro_end       = flag_next[3];
                    row_next.epilogue_begin = flag_next[4];
                    row_next.discriminator = disc_next;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            addr_reg   <= '0;
            file_reg   <= FILE_W'(1);
            line_reg   <= LINE_W'(1);
            column_reg <= '0;
            flag_reg   <= 5'b00001;
            disc_reg   <= '0;
            resume_reg <= RES_NONE;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            file_reg   <= file_next;
            line_reg   <= line_next;
            column_reg <= column_next;
            flag_reg   <= flag_next;
            disc_reg   <= disc_next;
            resume_reg <= resume_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        row_reg <= row_next;
    end

    property p_hold_stalled;
        @(posedge aclk) disable iff (!aresetn)
            (row_valid && !row_ready) |=> row_valid;
    endproperty
    a_hold_stalled: assert property (p_hold_stalled)
        else $error("result dropped while stalled");

    property p_div_len;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == BK_DIV) |-> (cnt_reg <= 4'd7);
    endproperty
    a_div_len: assert property (p_div_len)
        else $error("divider ran past eight steps");

    property p_end_full;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == BK_APPLY && cur_reg.cmd == CMD_END_SEQ)
            |=> (resume_reg == RES_FULL);
    endproperty
    a_end_full: assert property (p_end_full)
        else $error("end of sequence did not schedule full reset");

endmodule

/* tb/sv/dwarf_line_program_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwarf_line_program_engine_test
// Feeds line-number program bytes (opcodes, LEB and fixed operands, extended
// ops, restarts, noise) under several register settings, predicts each row
// with an in-bench decoder and checks every emitted row field by field.
// ----------------------------------------------------------------------------
module dwarf_line_program_engine_test;
    import dlpe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_BYTES = 230;

    typedef struct packed {
        logic       restart;
        logic [7:0] code;
    } prog_byte_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = 4'd0;
    logic [31:0]  pwdata = 32'd0;
    logic [31:0]  prdata;
    logic         pready;

    dwarf_line_program_engine DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // decoder configuration and row registers
    logic        cfg_default_stmt = 1'b1;
    logic [7:0]  cfg_lbase = 8'hFB;
    logic [7:0]  cfg_lrange = 8'd14;
    logic [7:0]  cfg_obase = 8'd13;
    logic [27:0] dec_addr;
    logic [15:0] dec_file;
    logic [15:0] dec_line;
    logic [9:0]  dec_col;
    logic [4:0]  dec_flags;   // stmt, bb, end, prologue, epilogue
    logic [27:0] dec_disc;
    resume_t     dec_resume;
    phase_t      dec_phase;
    logic [31:0] dec_acc;
    int          dec_shift;

    row_t       expected_rows[$];
    prog_byte_t pending_bytes[$];
    int         errors = 0;
    int         rows_seen = 0;
    int         illegal_seen = 0;
    int         bytes_sent = 0;
    int         cycles = 0;
    bit         byte_taken = 1'b0;
    bit         hold_request = 1'b0;

    task automatic decoder_clear();
        dec_addr = '0; dec_file = 16'd1; dec_line = 16'd1; dec_col = '0;
        dec_flags = {4'b0, cfg_default_stmt}; dec_disc = '0;
        dec_resume = RES_NONE; dec_phase = PH_OPCODE; dec_acc = '0; dec_shift = 0;
    endtask

    task automatic operand_start(phase_t ph);
        dec_acc = '0; dec_shift = 0; dec_phase = ph;
    endtask

    function automatic bit leb_add(logic [7:0] b);
        if (dec_shift < 31) begin
            dec_acc = dec_acc | ({25'd0, b[6:0]} << dec_shift);
            dec_shift = dec_shift + 7;
        end
        return !b[7];
    endfunction

    function automatic bit fixed_add(logic [7:0] b, int nbits);
        if (dec_shift < 32) begin
            dec_acc = dec_acc | ({24'd0, b} << dec_shift);
            dec_shift = dec_shift + 8;
        end
        return dec_shift >= nbits;
    endfunction

    task automatic divide_step(logic [7:0] adj, output logic [7:0] q, output logic [7:0] r);
        if (cfg_lrange == 8'd0) begin
            q = 8'd255; r = adj;
        end else begin
            q = adj / cfg_lrange; r = adj % cfg_lrange;
        end
    endtask

    task automatic decode_byte(logic restart, logic [7:0] b);
        logic [7:0]  adj;
        logic [7:0]  q;
        logic [7:0]  r;
        logic [31:0] v;
        int          emit;
        row_t        row;
        emit = -1;
        if (restart) begin
            decoder_clear();
            return;
        end
        if (dec_resume == RES_FULL) decoder_clear();
        else if (dec_resume == RES_SOFT) begin
            dec_disc = '0;
            dec_flags = dec_flags & 5'b00101;
        end
        dec_resume = RES_NONE;
        case (dec_phase)
            PH_OPCODE: begin
                if (b >= cfg_obase) begin
                    adj = b - cfg_obase;
                    divide_step(adj, q, r);
                    dec_addr = dec_addr + 28'(q);
                    dec_line = dec_line + {{8{cfg_lbase[7]}}, cfg_lbase} + 16'(r);
                    emit = 0;
                end else begin
                    case (b)
                        OP_EXTENDED: operand_start(PH_EXT_LEN);
                        OP_COPY:     emit = 0;
                        OP_ADV_PC:   operand_start(PH_ADV_PC);
                        OP_ADV_LINE: operand_start(PH_ADV_LINE);
                        OP_SET_FILE: operand_start(PH_SET_FILE);
                        OP_SET_COL:  operand_start(PH_SET_COL);
                        OP_NEG_STMT: dec_flags[0] = ~dec_flags[0];
                        OP_SET_BB:   dec_flags[1] = 1'b1;
                        OP_CONST_ADD: begin
                            adj = 8'd255 - cfg_obase;
                            divide_step(adj, q, r);
                            dec_addr = dec_addr + 28'(q);
                        end
                        OP_FIXED_PC: operand_start(PH_FIXED_PC);
                        OP_SET_PRO:  dec_flags[3] = 1'b1;
                        OP_SET_EPI:  dec_flags[4] = 1'b1;
                        OP_SET_ISA:  operand_start(PH_SET_ISA);
                        default:     emit = 1;
                    endcase
                end
            end
            PH_EXT_LEN: if (leb_add(b)) dec_phase = PH_EXT_SUB;
            PH_EXT_SUB: begin
                dec_phase = PH_OPCODE;
                if (b == EXT_END_SEQ) begin
                    dec_flags[2] = 1'b1; emit = 0; dec_resume = RES_FULL;
                end else if (b == EXT_SET_ADDR) operand_start(PH_EXT_ADDR);
                else if (b == EXT_SET_DISC) operand_start(PH_EXT_DISC);
                else emit = 1;
            end
            PH_EXT_ADDR: if (fixed_add(b, 32)) begin
                dec_addr = dec_acc[27:0]; dec_phase = PH_OPCODE;
            end
            PH_FIXED_PC: if (fixed_add(b, 16)) begin
                dec_addr = dec_addr + 28'(dec_acc[15:0]); dec_phase = PH_OPCODE;
            end
            PH_EXT_DISC, PH_ADV_PC, PH_SET_FILE, PH_SET_COL, PH_SET_ISA: if (leb_add(b)) begin
                v = dec_acc & 32'h0FFFFFFF;
                case (dec_phase)
                    PH_EXT_DISC: dec_disc = v[27:0];
                    PH_ADV_PC:   dec_addr = dec_addr + v[27:0];
                    PH_SET_FILE: dec_file = v[15:0];
                    PH_SET_COL:  dec_col = v[9:0];
                    default: ;
                endcase
                dec_phase = PH_OPCODE;
            end
            PH_ADV_LINE: if (leb_add(b)) begin
                v = dec_acc;
                // sign extend short sleb values only
                if (dec_shift < 31 && dec_shift > 0 && v[dec_shift-1])
                    v = v | (32'hFFFFFFFF << dec_shift);
                dec_line = dec_line + v[15:0];
                dec_phase = PH_OPCODE;
            end
            default: dec_phase = PH_OPCODE;
        endcase
        if (emit < 0) return;
        if (emit == 1) dec_resume = RES_FULL;
        else if (dec_resume == RES_NONE) dec_resume = RES_SOFT;
        row.status = (emit == 1);
        row.address = dec_addr; row.file = dec_file; row.line = dec_line;
        row.column = dec_col; row.is_stmt = dec_flags[0];
        row.basic_block = dec_flags[1]; row.end_seq = dec_flags[2];
        row.pro_end = dec_flags[3]; row.epilogue_begin = dec_flags[4];
        row.discriminator = dec_disc;
        expected_rows.push_back(row);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("row mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // monitor: predict on each accepted byte, check each accepted row
    always @(posedge aclk) begin
        row_t want;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tuser, s_tdata);
                byte_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("unexpected row", 32'(m_tdata[27:0]), 32'd0);
                end else begin
                    want = expected_rows.pop_front();
                    rows_seen++;
                    if (want.status) illegal_seen++;
                    if (m_tuser != want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[27:0] != want.address)
                        report_mismatch("address", 32'(m_tdata[27:0]), 32'(want.address));
                    if (m_tdata[43:28] != want.file)
                        report_mismatch("file", 32'(m_tdata[43:28]), 32'(want.file));
                    if (m_tdata[59:44] != want.line)
                        report_mismatch("line", 32'(m_tdata[59:44]), 32'(want.line));
                    if (m_tdata[69:60] != want.column)
                        report_mismatch("column", 32'(m_tdata[69:60]), 32'(want.column));
                    if (m_tdata[70] != want.is_stmt)
                        report_mismatch("is_stmt", 32'(m_tdata[70]), 32'(want.is_stmt));
                    if (m_tdata[71] != want.basic_block)
                        report_mismatch("basic_block", 32'(m_tdata[71]),
                                        32'(want.basic_block));
                    if (m_tdata[72] != want.end_seq)
                        report_mismatch("end_seq", 32'(m_tdata[72]), 32'(want.end_seq));
                    if (m_tdata[73] != want.pro_end)
                        report_mismatch("pro_end", 32'(m_tdata[73]), 32'(want.pro_end));
                    if (m_tdata[74] != want.epilogue_begin)
                        report_mismatch("epilogue_begin", 32'(m_tdata[74]),
                                        32'(want.epilogue_begin));
                    if (m_tdata[102:75] != want.discriminator)
                        report_mismatch("discriminator", 32'(m_tdata[102:75]),
                                        32'(want.discriminator));
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout with %0d rows outstanding", expected_rows.size());
                $display("dwarf_line_program_engine_test: errors");
                $finish;
            end
        end
    end

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        prog_byte_t nxt;
        if (aresetn) begin
            if (s_tvalid && !byte_taken) begin
                // hold the offered transaction
            end else if (gap_left > 0 || pending_bytes.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                nxt = pending_bytes.pop_front();
                bytes_sent++;
                s_tvalid <= 1'b1;
                s_tuser <= nxt.restart;
                s_tdata <= nxt.code;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                      : $urandom_range(20, 80);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end
            end
            byte_taken = 1'b0;
        end
    end

    // receiver: stall pattern plus long hold-off on request
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_request && hold_left == 0) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end else mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic put_byte(logic [7:0] b);
        pending_bytes.push_back('{restart: 1'b0, code: b});
    endtask

    task automatic put_restart();
        pending_bytes.push_back('{restart: 1'b1, code: 8'($urandom_range(0, 255))});
    endtask

    // leb operand of n bytes with random payload
    task automatic put_leb(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            b[7] = (i != n - 1);
            put_byte(b);
        end
    endtask

    task automatic put_fixed(int n);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int leb_len();
        return $urandom_range(0, 5) == 0 ? $urandom_range(4, 7) : $urandom_range(1, 3);
    endfunction

    task automatic put_instruction();
        int pick;
        pick = $urandom_range(0, 31);
        if (pick < 8) put_byte(8'($urandom_range(cfg_obase, 255)));
        else if (pick < 10) put_byte(OP_COPY);
        else if (pick < 11) begin put_byte(OP_ADV_PC); put_leb(leb_len()); end
        else if (pick < 13) begin put_byte(OP_ADV_LINE); put_leb(leb_len()); end
        else if (pick < 14) begin put_byte(OP_SET_FILE); put_leb(leb_len()); end
        else if (pick < 15) begin put_byte(OP_SET_COL); put_leb(leb_len()); end
        else if (pick < 16) put_byte(OP_NEG_STMT);
        else if (pick < 17) put_byte(OP_SET_BB);
        else if (pick < 18) put_byte(OP_CONST_ADD);
        else if (pick < 19) begin put_byte(OP_FIXED_PC); put_fixed(2); end
        else if (pick < 20) put_byte(OP_SET_PRO);
        else if (pick < 21) put_byte(OP_SET_EPI);
        else if (pick < 22) begin put_byte(OP_SET_ISA); put_leb(leb_len()); end
        else if (pick < 23) begin
            put_byte(OP_EXTENDED); put_leb(leb_len()); put_byte(EXT_END_SEQ);
        end else if (pick < 25) begin
            put_byte(OP_EXTENDED); put_leb(1); put_byte(EXT_SET_ADDR); put_fixed(4);
        end else if (pick < 26) begin
            put_byte(OP_EXTENDED); put_leb(1); put_byte(EXT_SET_DISC); put_leb(leb_len());
        end else if (pick < 27) begin
            put_byte(OP_EXTENDED); put_leb(1); put_byte(8'($urandom_range(0, 255)));
        end else if (pick < 28) put_restart();
        else if (pick < 29) begin
            // restart dropping a partial operand
            put_byte(8'($urandom_range(OP_ADV_PC, OP_SET_COL)));
            put_byte(8'(8'h80 | $urandom));
            put_restart();
        end else put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_bytes.size() == 0 && !s_tvalid && expected_rows.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic stmt, logic [7:0] lb, logic [7:0] lr, logic [7:0] ob);
        wait_idle();
        apb_write(4'd0, {31'd0, stmt});
        apb_write(4'd4, {24'd0, lb});
        apb_write(4'd8, {24'd0, lr});
        apb_write(4'd12, {24'd0, ob});
        cfg_default_stmt = stmt; cfg_lbase = lb;
        cfg_lrange = lr; cfg_obase = ob;
        // new is_stmt default only shows after a full reset
        put_restart();
    endtask

    task automatic random_phase(bit long_hold);
        int start;
        start = bytes_sent + pending_bytes.size();
        if (long_hold) hold_request = 1'b1;
        while (bytes_sent + pending_bytes.size() - start < PHASE_BYTES) begin
            put_instruction();
            if (pending_bytes.size() > 40) wait (pending_bytes.size() < 10);
        end
    endtask

    initial begin
        decoder_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every opcode and the corner cases
        put_byte(8'd255); put_byte(8'd13); put_byte(OP_COPY);
        put_byte(OP_NEG_STMT); put_byte(OP_SET_BB); put_byte(OP_SET_PRO);
        put_byte(OP_SET_EPI); put_byte(OP_CONST_ADD); put_byte(OP_COPY);
        put_byte(OP_EXTENDED); put_byte(8'h05); put_byte(EXT_SET_ADDR);
        put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
        put_byte(OP_EXTENDED); put_byte(8'h81); put_byte(8'h00); put_byte(EXT_SET_DISC);
        for (int i = 0; i < 6; i++) put_byte(8'hFF);
        put_byte(8'h7F); put_byte(OP_ADV_LINE); put_byte(8'h40);
        put_byte(OP_ADV_LINE); for (int i = 0; i < 4; i++) put_byte(8'hFF); put_byte(8'h7F);
        put_byte(OP_SET_COL); put_byte(8'hFF); put_byte(8'h7F);
        put_byte(OP_SET_FILE); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'h03);
        put_byte(OP_FIXED_PC); put_byte(8'hFF); put_byte(8'hFF);
        put_byte(OP_SET_ISA); put_byte(8'h85); put_byte(8'h01);
        put_byte(OP_ADV_PC); put_byte(8'h80); put_restart(); put_byte(OP_COPY);
        put_byte(OP_EXTENDED); put_byte(8'h01); put_byte(EXT_END_SEQ); put_byte(OP_COPY);
        put_byte(OP_EXTENDED); put_byte(8'h01); put_byte(8'h03); put_byte(OP_COPY);

        random_phase(1'b1);
        set_config(1'b0, 8'h80, 8'd1, 8'd1);
        random_phase(1'b0);
        set_config(1'b1, 8'h7F, 8'd255, 8'd255);
        put_byte(8'd200); put_byte(8'd13); put_byte(OP_CONST_ADD); put_byte(OP_COPY);
        random_phase(1'b1);
        set_config(1'b0, 8'h00, 8'd3, 8'd20);
        put_byte(8'd19); put_byte(8'd14); put_byte(OP_COPY);
        random_phase(1'b0);
        set_config(1'b1, 8'hFB, 8'd14, 8'd13);
        random_phase(1'b0);
        set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
        random_phase(1'b1);

        wait_idle();
        $display("sent %0d program bytes over six register settings", bytes_sent);
        $display("checked %0d rows, %0d of them illegal-opcode results", rows_seen, illegal_seen);
        if (errors == 0) begin
            $display("dwarf_line_program_engine_test: clean");
        end else begin
            $display("dwarf_line_program_engine_test: errors");
        end
        $finish;
    end

endmodule

/* dwarf_line_program_engine.f */
rtl/dlpe_pkg.sv
rtl/dlpe_front.sv
rtl/dlpe_queue.sv
rtl/dlpe_back.sv
rtl/dwarf_line_program_engine.sv
tb/sv/dwarf_line_program_engine_test.sv
